[rtl/ssc_pkg.sv]
// Shared types and state codes for the stack sequence checker.
package ssc_pkg;

	localparam int unsigned SYMBOL_W = 8;

	// One input transaction as it travels from the front queue to the sequencer.
	typedef struct packed {
		logic                last_item;
		logic [SYMBOL_W-1:0] expect_symbol;
		logic [SYMBOL_W-1:0] push_symbol;
	} item_t;

	typedef struct packed {
		logic length_exceeded;
		logic achievable;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_EMIT = 4'b1000
	} seq_state_t;

endpackage

[rtl/ssc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ssc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/ssc_front.sv]
// Input side: unpacks stream transactions into items and holds them in a two-entry queue.
module ssc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [15:0]    s_tdata,
	input  logic           s_tlast,
	output logic           q_valid,
	input  logic           q_ready,
	output ssc_pkg::item_t q_item
);

	ssc_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;
	ssc_pkg::item_t in_item;

	always_comb begin
		in_item.push_symbol   = s_tdata[7:0];
		in_item.expect_symbol = s_tdata[15:8];
		in_item.last_item     = s_tlast;
	end

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/ssc_back.sv]
// Sequencer: pushes each item unless the run is too long, pops while the stack top matches, and issues the verdict.
module ssc_back #(
	parameter int unsigned MAX_LENGTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  ssc_pkg::item_t   q_item,
	output logic             out_valid,
	input  logic             out_ready,
	output ssc_pkg::result_t out_result
);

	localparam int unsigned ADDR_W = $clog2(MAX_LENGTH);
	localparam int unsigned CNT_W  = $clog2(MAX_LENGTH + 1);

	ssc_pkg::seq_state_t state_q;
	logic [CNT_W-1:0]    rc_q;
	logic [CNT_W-1:0]    depth_q;
	logic [CNT_W-1:0]    mi_q;
	logic                ov_q;
	logic                last_q;
	logic                out_valid_q;
	ssc_pkg::result_t    result_q;

	logic                       take;
	logic                       full;
	logic                       store;
	logic                       emit_fire;
	logic [CNT_W-1:0]           depth_m1;
	logic [ssc_pkg::SYMBOL_W-1:0] stack_rd;
	logic [ssc_pkg::SYMBOL_W-1:0] exp_rd;
	logic                       match;

	assign q_ready    = (state_q == ssc_pkg::ST_IDLE);
	assign take       = q_valid && q_ready;
	assign full       = (rc_q == CNT_W'(MAX_LENGTH));
	assign store      = take && !ov_q && !full;
	assign depth_m1   = depth_q - CNT_W'(1);
	assign emit_fire  = (state_q == ssc_pkg::ST_EMIT) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_result = result_q;

	ssc_ram #(
		.WIDTH(ssc_pkg::SYMBOL_W),
		.DEPTH(MAX_LENGTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (store),
		.waddr (depth_q[ADDR_W-1:0]),
		.wdata (q_item.push_symbol),
		.raddr (depth_m1[ADDR_W-1:0]),
		.rdata (stack_rd)
	);

	ssc_ram #(
		.WIDTH(ssc_pkg::SYMBOL_W),
		.DEPTH(MAX_LENGTH)
	) u_expected_ram (
		.clk   (clk),
		.we    (store),
		.waddr (rc_q[ADDR_W-1:0]),
		.wdata (q_item.expect_symbol),
		.raddr (mi_q[ADDR_W-1:0]),
		.rdata (exp_rd)
	);

	// Read data presented in the compare state belongs to the addresses driven in the read state.
	assign match = (depth_q != '0) && (mi_q < rc_q) && (stack_rd == exp_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssc_pkg::ST_IDLE;
			rc_q        <= '0;
			depth_q     <= '0;
			mi_q        <= '0;
			ov_q        <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ssc_pkg::ST_IDLE: begin
					if (take) begin
						last_q <= q_item.last_item;
						if (ov_q || full) begin
							// Too long: the transaction is dropped and the run is marked failed.
							ov_q    <= 1'b1;
							state_q <= q_item.last_item ? ssc_pkg::ST_EMIT : ssc_pkg::ST_IDLE;
						end else begin
							rc_q    <= rc_q + CNT_W'(1);
							depth_q <= depth_q + CNT_W'(1);
							state_q <= ssc_pkg::ST_READ;
						end
					end
				end
				ssc_pkg::ST_READ: begin
					state_q <= ssc_pkg::ST_CMP;
				end
				ssc_pkg::ST_CMP: begin
					if (match) begin
						depth_q <= depth_m1;
						mi_q    <= mi_q + CNT_W'(1);
					end
					if (match && depth_m1 != '0) begin
						state_q <= ssc_pkg::ST_READ;
					end else begin
						state_q <= last_q ? ssc_pkg::ST_EMIT : ssc_pkg::ST_IDLE;
					end
				end
				ssc_pkg::ST_EMIT: begin
					if (emit_fire) begin
						result_q.achievable      <= !ov_q && (depth_q == '0) && (mi_q == rc_q);
						result_q.length_exceeded <= ov_q;
						rc_q                     <= '0;
						depth_q                  <= '0;
						mi_q                     <= '0;
						ov_q                     <= 1'b0;
						state_q                  <= ssc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ssc_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/stack_sequence_checker.sv]
// Top level of the stack sequence checker: input queue, push/pop sequencer and result port.
//
// Each input transaction carries one push symbol, the pop-sequence symbol at the same
// position and a last flag; the transaction with s_tlast set closes the run and yields one
// result transaction with the verdict, after which the block starts a new run. A two-entry
// queue takes transactions while the sequencer works. In the sequencer an item is taken in
// the idle state; then the stack top is compared with the expected symbol in a read state and
// a compare state, repeated for each symbol popped from the stack, as set by the registered
// read of the stack and expected-symbol memories; a closing item then passes through the emit
// state for the verdict. Every symbol is popped at most once. Runs longer than MAX_LENGTH fail
// with length_exceeded set. No memory clearing is needed after reset, so the block accepts
// transactions right away.
module stack_sequence_checker #(
	parameter int unsigned MAX_LENGTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] push_symbol, [15:8] expect_symbol
	input  logic        s_tlast,   // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] achievable, [1] length_exceeded, [7:2] zero
);

	logic             q_valid;
	logic             q_ready;
	ssc_pkg::item_t   q_item;
	ssc_pkg::result_t result;

	ssc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	ssc_back #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {6'b0, result.length_exceeded, result.achievable};

endmodule
